// ----- sv/tcc_pkg.sv -----
// Shared types, constants and helper functions for the text console engine.
// Used by tcc_ctrl, tcc_datapath and text_console_cursor_scroll_top; no dependencies.
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int COLX_W   = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWX_W   = $clog2(ROWS + 1);
    localparam int NTAB     = (COLUMNS - 1) / TAB_WIDTH + 1;

    // Fixed field widths of the transaction payloads
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [3:0]        background_color;
        logic [3:0]        foreground_color;
        logic [LOC_W-1:0]  cell_address;
    } in_item_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_location;
        logic [CELL_W-1:0] cell_data;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_BLANK,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        SW_NONE,
        SW_FILL,
        SW_COPY,
        SW_BLANK
    } sweep_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic   accept;
        logic   cnt_clr;
        sweep_t sweep_op;
        logic   load_result;
        logic   load_read;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic put_scroll;
        logic copy_end;
        logic fill_end;
    } status_t;

    // Next tab stop strictly above the given column
    function automatic logic [COLX_W-1:0] tab_stop(input logic [COL_W-1:0] col);
        logic [COLX_W-1:0] stop;
        stop = COLX_W'(NTAB * TAB_WIDTH);
        for (int m = NTAB; m >= 1; m--) begin
            if (m * TAB_WIDTH > int'(col)) begin
                stop = COLX_W'(m * TAB_WIDTH);
            end
        end
        return stop;
    endfunction

endpackage

// ----- sv/tcc_ctrl.sv -----
// Controller state machine: handshake, buffer sweeps and result loading.
// Depends on tcc_pkg; drives tcc_datapath through ctrl_t and reads status_t.
module tcc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tcc_pkg::CMD_W-1:0]  in_cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  tcc_pkg::status_t           st,
    output tcc_pkg::ctrl_t             ctrl
);

    tcc_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == tcc_pkg::ST_IDLE) && slot_free;
    assign m_valid   = m_valid_reg;

    // Hold state and result flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcc_pkg::ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        ctrl.accept      = 1'b0;
        ctrl.cnt_clr     = 1'b0;
        ctrl.sweep_op    = tcc_pkg::SW_NONE;
        ctrl.load_result = 1'b0;
        ctrl.load_read   = 1'b0;
        unique case (state_reg)
            tcc_pkg::ST_INIT: begin
                ctrl.sweep_op = tcc_pkg::SW_FILL;
                if (st.fill_end) begin
                    state_next = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_IDLE: begin
                if (s_valid && slot_free) begin
                    ctrl.accept = 1'b1;
                    unique case (in_cmd)
                        tcc_pkg::CMD_PUT: begin
                            if (st.put_scroll) begin
                                ctrl.cnt_clr = 1'b1;
                                state_next   = tcc_pkg::ST_COPY;
                            end else begin
                                ctrl.load_result = 1'b1;
                            end
                        end
                        tcc_pkg::CMD_CLEAR: begin
                            ctrl.cnt_clr = 1'b1;
                            state_next   = tcc_pkg::ST_FILL;
                        end
                        tcc_pkg::CMD_READ: begin
                            state_next = tcc_pkg::ST_READ;
                        end
                        tcc_pkg::CMD_NONE: begin
                            ctrl.load_result = 1'b1;
                        end
                    endcase
                end
            end
            tcc_pkg::ST_FILL: begin
                ctrl.sweep_op = tcc_pkg::SW_FILL;
                if (st.fill_end) begin
                    ctrl.load_result = 1'b1;
                    state_next       = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_COPY: begin
                ctrl.sweep_op = tcc_pkg::SW_COPY;
                if (st.copy_end) begin
                    state_next = tcc_pkg::ST_BLANK;
                end
            end
            tcc_pkg::ST_BLANK: begin
                ctrl.sweep_op = tcc_pkg::SW_BLANK;
                if (st.fill_end) begin
                    ctrl.load_result = 1'b1;
                    state_next       = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_READ: begin
                ctrl.load_result = 1'b1;
                ctrl.load_read   = 1'b1;
                state_next       = tcc_pkg::ST_IDLE;
            end
            default: begin
                state_next = tcc_pkg::ST_INIT;
            end
        endcase
    end

    // Set on load, drop when taken
    always_comb begin
        if (ctrl.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // A result never overwrites one still waiting
    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_result |-> slot_free)
        else $error("result loaded while output register full");

    // A clear transaction starts the fill sweep
    a_clear_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.accept && in_cmd == tcc_pkg::CMD_CLEAR) |=> state_reg == tcc_pkg::ST_FILL)
        else $error("clear did not start fill sweep");

    // The copy phase always hands over to the bottom row blanking
    a_copy_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcc_pkg::ST_COPY && st.copy_end) |=> state_reg == tcc_pkg::ST_BLANK)
        else $error("scroll copy not followed by blanking");

    // No transaction taken during any sweep
    a_sweep_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.sweep_op != tcc_pkg::SW_NONE) |-> !s_ready)
        else $error("input ready during buffer sweep");

endmodule

// ----- sv/tcc_datapath.sv -----
// Datapath: cell buffer memory, cursor registers, sweep counter and result register.
// Depends on tcc_pkg; commanded by tcc_ctrl through ctrl_t.
module tcc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcc_pkg::in_item_t  in_item,
    input  tcc_pkg::ctrl_t     ctrl,
    output tcc_pkg::status_t   st,
    output tcc_pkg::out_item_t out_item
);

    // Cell buffer
    logic [tcc_pkg::CELL_W-1:0] mem [tcc_pkg::CELLS];
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;
    logic                       we, re;
    logic [tcc_pkg::ADDR_W-1:0] waddr, raddr;
    logic [tcc_pkg::CELL_W-1:0] wdata;

    logic [tcc_pkg::COL_W-1:0]  col_reg;
    logic [tcc_pkg::ROW_W-1:0]  row_reg;
    logic [tcc_pkg::ADDR_W-1:0] cnt_reg;
    logic                       rd_ok_reg;
    logic [tcc_pkg::CELL_W-1:0] out_cell_reg;

    logic [tcc_pkg::COLX_W-1:0] col_a;
    logic [tcc_pkg::ROWX_W-1:0] row_a;
    logic                       printable;
    logic                       put_scroll;
    logic [tcc_pkg::COL_W-1:0]  col_put;
    logic [tcc_pkg::ROW_W-1:0]  row_put;
    logic [tcc_pkg::ADDR_W-1:0] cur_idx;
    logic                       addr_ok;
    logic                       is_put, is_clear, is_read;

    assign is_put   = ctrl.accept && (in_item.command == tcc_pkg::CMD_PUT);
    assign is_clear = ctrl.accept && (in_item.command == tcc_pkg::CMD_CLEAR);
    assign is_read  = ctrl.accept && (in_item.command == tcc_pkg::CMD_READ);
    assign addr_ok  = in_item.cell_address < tcc_pkg::LOC_W'(tcc_pkg::CELLS);

    assign cur_idx = tcc_pkg::ADDR_W'(row_reg) * tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS)
                   + tcc_pkg::ADDR_W'(col_reg);

    // Decode put character and advance the cursor
    always_comb begin
        col_a     = tcc_pkg::COLX_W'(col_reg);
        row_a     = tcc_pkg::ROWX_W'(row_reg);
        printable = 1'b0;
        unique case (in_item.char_code)
            tcc_pkg::CH_BS: begin
                if (col_reg != '0) begin
                    col_a = tcc_pkg::COLX_W'(col_reg - tcc_pkg::COL_W'(1));
                end
            end
            tcc_pkg::CH_TAB: begin
                col_a = tcc_pkg::tab_stop(col_reg);
            end
            tcc_pkg::CH_CR: begin
                col_a = '0;
            end
            tcc_pkg::CH_LF: begin
                col_a = '0;
                row_a = row_a + tcc_pkg::ROWX_W'(1);
            end
            default: begin
                if (in_item.char_code >= tcc_pkg::CH_SPACE &&
                    in_item.char_code <= tcc_pkg::CH_DEL) begin
                    printable = 1'b1;
                    col_a     = tcc_pkg::COLX_W'(col_reg) + tcc_pkg::COLX_W'(1);
                end
            end
        endcase
        // Wrap past the last column
        if (col_a >= tcc_pkg::COLX_W'(tcc_pkg::COLUMNS)) begin
            col_a = '0;
            row_a = row_a + tcc_pkg::ROWX_W'(1);
        end
        // Pin to the last row when a scroll follows
        put_scroll = row_a >= tcc_pkg::ROWX_W'(tcc_pkg::ROWS);
        col_put    = tcc_pkg::COL_W'(col_a);
        row_put    = put_scroll ? tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1)
                                : tcc_pkg::ROW_W'(row_a);
    end

    assign st.put_scroll = put_scroll;
    assign st.copy_end   = cnt_reg == tcc_pkg::ADDR_W'(tcc_pkg::COPY_LEN);
    assign st.fill_end   = cnt_reg == tcc_pkg::ADDR_W'(tcc_pkg::CELLS - 1);

    // Select memory port operations
    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = cnt_reg;
        raddr = cnt_reg + tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS);
        wdata = tcc_pkg::BLANK_CELL;
        unique case (ctrl.sweep_op)
            tcc_pkg::SW_FILL, tcc_pkg::SW_BLANK: begin
                we = 1'b1;
            end
            tcc_pkg::SW_COPY: begin
                // Read a row ahead, write in the cycle after the read
                re    = cnt_reg < tcc_pkg::ADDR_W'(tcc_pkg::COPY_LEN);
                we    = cnt_reg != '0;
                waddr = cnt_reg - tcc_pkg::ADDR_W'(1);
                wdata = rdata_reg;
            end
            tcc_pkg::SW_NONE: begin
                we    = is_put && printable;
                waddr = cur_idx;
                wdata = {in_item.background_color, in_item.foreground_color,
                         in_item.char_code};
                re    = is_read && addr_ok;
                raddr = tcc_pkg::ADDR_W'(in_item.cell_address);
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Cursor and sweep counter; hold the counter on the first bottom row cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (is_put) begin
                col_reg <= col_put;
                row_reg <= row_put;
            end else if (is_clear) begin
                col_reg <= '0;
                row_reg <= '0;
            end
            if (ctrl.cnt_clr) begin
                cnt_reg <= '0;
            end else if (ctrl.sweep_op != tcc_pkg::SW_NONE &&
                         !(ctrl.sweep_op == tcc_pkg::SW_COPY && st.copy_end)) begin
                cnt_reg <= cnt_reg + tcc_pkg::ADDR_W'(1);
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (is_read) begin
            rd_ok_reg <= addr_ok;
        end
        if (ctrl.load_result) begin
            out_cell_reg <= (ctrl.load_read && rd_ok_reg) ? rdata_reg : '0;
        end
    end

    assign out_item.cursor_location = tcc_pkg::LOC_W'(cur_idx);
    assign out_item.cell_data       = out_cell_reg;

endmodule

// ----- sv/text_console_cursor_scroll_top.sv -----
// Text console engine: put character, clear and read cell on a cell buffer.
// Put without scroll and unused commands: result at the accepting edge, one per cycle while results are taken.
// Read: the cell comes through the registered read port of the cell buffer, then the READ state loads it.
// Scroll: one cell copied or blanked per cycle on one write port.
// Clear: a fill pass blanks all CELLS cells. After reset a clearing pass runs, input not ready.
// Depends on tcc_pkg, tcc_ctrl and tcc_datapath.
module text_console_cursor_scroll_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcc_pkg::out_item_t m_data
);

    tcc_pkg::ctrl_t   ctrl;
    tcc_pkg::status_t st;

    // Sequence transactions and sweeps
    tcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_cmd  (s_data.command),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .ctrl    (ctrl)
    );

    // Hold buffer, cursor and result
    tcc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .ctrl     (ctrl),
        .st       (st),
        .out_item (m_data)
    );

endmodule
